// ===== hdl/ghull_pkg.sv =====
// ----------------------------------------------------------------------------
// ghull_pkg
// Shared types, codes and the CORDIC arctangent table for the hull block.
// ----------------------------------------------------------------------------
package ghull_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int CORDIC_ITERS = 28;
	localparam int CORDIC_GUARD = 16;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_FEW_POINTS,
		ERR_NO_CANDIDATE,
		ERR_STEP_OVERFLOW
	} err_code_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   last_point;
	} in_item_t;

	typedef struct packed {
		coord_t    hull_x;
		coord_t    hull_y;
		logic      last_vertex;
		err_code_t error_code;
	} out_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MIN_RD,
		ST_MIN_EV,
		ST_INIT,
		ST_SEL_RD,
		ST_SEL_EV,
		ST_CORD_GO,
		ST_CORD_WAIT,
		ST_CMP,
		ST_PICK,
		ST_EMIT_RD,
		ST_EMIT_EV,
		ST_ERR,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic      load_pt;
		logic      scan_clr;
		logic      scan_inc;
		logic      min_eval;
		logic      wrap_init;
		logic      cand_load;
		logic      cord_start;
		logic      cand_cmp;
		logic      pick;
		logic      advance;
		logic      emit_vertex;
		logic      emit_err;
		logic      set_err;
		err_code_t err;
		logic      wrap_clear;
	} cmd_t;

	typedef struct packed {
		logic count_lt2;
		logic scan_last;
		logic skip;
		logic cord_busy;
		logic found;
		logic step_ovf;
		logic closes;
		logic k_full;
		logic emit_last;
		logic out_free;
	} status_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_unit(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/ghull_cordic.sv =====
// ----------------------------------------------------------------------------
// ghull_cordic
// Iterative vectoring CORDIC: first-quadrant angle of (ax, ay), one step a cycle.
// ----------------------------------------------------------------------------
module ghull_cordic #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [ghull_pkg::COORD_WIDTH-1:0]       ax,
	input  logic [ghull_pkg::COORD_WIDTH-1:0]       ay,
	output logic                                    busy,
	output logic [ANGLE_WIDTH-2:0]                  q
);
	localparam int XW  = ghull_pkg::COORD_WIDTH + ghull_pkg::CORDIC_GUARD + 3;
	localparam int ZW  = 34;
	localparam int ITW = $clog2(ghull_pkg::CORDIC_ITERS);
	localparam int S   = 32 - ANGLE_WIDTH;

	logic signed [XW-1:0] x_q, y_q, xs, ys, nx, ny;
	logic signed [ZW-1:0] z_q, nz, at;
	logic [ITW-1:0]       iter_q;
	logic                 busy_q;
	logic [30:0]          zc, rnd;

	always_comb begin
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at = $signed({2'b00, ghull_pkg::atan_unit(5'(iter_q))});
		if (!y_q[XW-1]) begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + at;
		end else begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			iter_q <= '0;
			busy_q <= (ay != '0) && (ax != '0);
		end else if (busy_q) begin
			iter_q <= ITW'(iter_q + 1'b1);
			if (iter_q == ITW'(ghull_pkg::CORDIC_ITERS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XW'(ax) <<< ghull_pkg::CORDIC_GUARD;
			y_q <= XW'(ay) <<< ghull_pkg::CORDIC_GUARD;
			// axis cases resolve at once: zero on the x axis, a quarter turn on the y axis
			if (ay == '0) begin
				z_q <= '0;
			end else if (ax == '0) begin
				z_q <= ZW'(64'sd1 <<< 30);
			end else begin
				z_q <= '0;
			end
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	always_comb begin
		if (z_q[ZW-1]) begin
			zc = '0;
		end else if (z_q > ZW'(64'sd1 <<< 30)) begin
			zc = 31'(32'd1 << 30);
		end else begin
			zc = z_q[30:0];
		end
		rnd = zc + 31'(32'd1 << (S - 1));
	end

	assign q    = rnd[30:S];
	assign busy = busy_q;

endmodule

// ===== hdl/ghull_dp.sv =====
// ----------------------------------------------------------------------------
// ghull_dp
// Hull datapath: point store, vertex list, used flags, angle compare, output.
// ----------------------------------------------------------------------------
module ghull_dp #(
	parameter int MAX_POINTS  = 64,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ghull_pkg::cmd_t      cmd,
	output ghull_pkg::status_t   sts,
	input  ghull_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ghull_pkg::out_item_t out_data
);
	localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int AW1  = ANGLE_WIDTH + 1;
	localparam int CW   = ghull_pkg::COORD_WIDTH;

	localparam logic [AW1-1:0] FULL_TURN = AW1'(1) << ANGLE_WIDTH;
	localparam logic [AW1-1:0] HALF_TURN = AW1'(1) << (ANGLE_WIDTH - 1);

	ghull_pkg::point_t store_mem [MAX_POINTS];
	ghull_pkg::point_t list_mem  [MAX_POINTS];
	ghull_pkg::point_t store_rd_q, list_rd_q;
	ghull_pkg::point_t cand_q, best_pt_q, start_q, cur_q;

	logic [MAX_POINTS-1:0] used_q;
	logic [CNTW-1:0]       count_q, k_q, steps_q;
	logic [IW-1:0]         scan_q, best_idx_q;
	logic [AW1-1:0]        prev_q, best_diff_q, best_angle_q, ang, diff, qe;
	logic                  found_q, dx_neg_q, dy_neg_q;
	ghull_pkg::err_code_t  err_q;
	logic                  out_valid_q;
	ghull_pkg::out_item_t  out_q;

	logic signed [CW:0]    dx, dy;
	logic [CW:0]           adx, ady;
	logic                  cord_busy;
	logic [ANGLE_WIDTH-2:0] cord_q;

	always_comb begin
		dx  = $signed({cand_q.x[CW-1], cand_q.x}) - $signed({cur_q.x[CW-1], cur_q.x});
		dy  = $signed({cand_q.y[CW-1], cand_q.y}) - $signed({cur_q.y[CW-1], cur_q.y});
		adx = dx[CW] ? (CW+1)'(-dx) : dx;
		ady = dy[CW] ? (CW+1)'(-dy) : dy;
	end

	ghull_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cord_start),
		.ax     (adx[CW-1:0]),
		.ay     (ady[CW-1:0]),
		.busy   (cord_busy),
		.q      (cord_q)
	);

	always_comb begin
		qe = AW1'(cord_q);
		if (!dy_neg_q) begin
			ang = dx_neg_q ? AW1'(FULL_TURN - qe) : AW1'(HALF_TURN + qe);
		end else begin
			ang = dx_neg_q ? qe : AW1'(HALF_TURN - qe);
		end
		diff = AW1'(prev_q - ang);
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load_pt && (count_q < CNTW'(MAX_POINTS))) begin
			store_mem[count_q[IW-1:0]] <= '{x: in_data.point_x, y: in_data.point_y};
		end
		store_rd_q <= store_mem[scan_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wrap_init) begin
			list_mem[0] <= best_pt_q;
		end else if (cmd.advance) begin
			list_mem[k_q[IW-1:0]] <= best_pt_q;
		end
		list_rd_q <= list_mem[scan_q];
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			used_q      <= '0;
			scan_q      <= '0;
			k_q         <= '0;
			steps_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			prev_q      <= FULL_TURN;
			start_q     <= '0;
			cur_q       <= '0;
		end else begin
			if (cmd.load_pt && (count_q < CNTW'(MAX_POINTS))) begin
				count_q <= CNTW'(count_q + 1'b1);
			end
			if (cmd.scan_clr || cmd.wrap_init || cmd.advance) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= IW'(scan_q + 1'b1);
			end
			if (cmd.wrap_init) begin
				start_q <= best_pt_q;
				cur_q   <= best_pt_q;
				prev_q  <= FULL_TURN;
				k_q     <= CNTW'(1);
				steps_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.cand_cmp && (ang <= prev_q) && (diff < best_diff_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.pick) begin
				used_q[best_idx_q] <= 1'b1;
				prev_q             <= best_angle_q;
				steps_q            <= CNTW'(steps_q + 1'b1);
			end
			if (cmd.advance) begin
				cur_q   <= best_pt_q;
				k_q     <= CNTW'(k_q + 1'b1);
				found_q <= 1'b0;
			end
			if (cmd.wrap_clear) begin
				count_q <= '0;
				used_q  <= '0;
			end
			if (cmd.emit_vertex || cmd.emit_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.min_eval && ((scan_q == '0) || (store_rd_q.y < best_pt_q.y))) begin
			best_pt_q <= store_rd_q;
		end
		if (cmd.wrap_init || cmd.advance) begin
			best_diff_q <= FULL_TURN;
		end
		if (cmd.cand_load) begin
			cand_q <= store_rd_q;
		end
		if (cmd.cord_start) begin
			dx_neg_q <= dx[CW];
			dy_neg_q <= dy[CW];
		end
		if (cmd.cand_cmp && (ang <= prev_q) && (diff < best_diff_q)) begin
			best_diff_q  <= diff;
			best_angle_q <= ang;
			best_idx_q   <= scan_q;
			best_pt_q    <= cand_q;
		end
		if (cmd.set_err) begin
			err_q <= cmd.err;
		end
		if (cmd.emit_vertex) begin
			out_q.hull_x      <= list_rd_q.x;
			out_q.hull_y      <= list_rd_q.y;
			out_q.last_vertex <= sts.emit_last;
			out_q.error_code  <= ghull_pkg::ERR_NONE;
		end else if (cmd.emit_err) begin
			out_q.hull_x      <= '0;
			out_q.hull_y      <= '0;
			out_q.last_vertex <= 1'b1;
			out_q.error_code  <= err_q;
		end
	end

	always_comb begin
		sts.count_lt2 = count_q < CNTW'(2);
		sts.scan_last = CNTW'(CNTW'(scan_q) + CNTW'(1)) == count_q;
		sts.skip      = used_q[scan_q] || (store_rd_q == cur_q);
		sts.cord_busy = cord_busy;
		sts.found     = found_q;
		sts.step_ovf  = steps_q >= count_q;
		sts.closes    = best_pt_q == start_q;
		sts.k_full    = k_q >= CNTW'(MAX_POINTS);
		sts.emit_last = CNTW'(CNTW'(scan_q) + CNTW'(1)) == k_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/ghull_ctrl.sv =====
// ----------------------------------------------------------------------------
// ghull_ctrl
// Hull controller: load, lowest-point scan, candidate walk, emit or error result, clear.
// ----------------------------------------------------------------------------
module ghull_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_point,
	output logic               in_ready,
	input  ghull_pkg::status_t sts,
	output ghull_pkg::cmd_t    cmd
);
	ghull_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghull_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ghull_pkg::ST_IDLE: begin
				if (in_valid && last_point) state_d = ghull_pkg::ST_CHECK;
			end
			ghull_pkg::ST_CHECK: begin
				state_d = sts.count_lt2 ? ghull_pkg::ST_ERR : ghull_pkg::ST_MIN_RD;
			end
			ghull_pkg::ST_MIN_RD: state_d = ghull_pkg::ST_MIN_EV;
			ghull_pkg::ST_MIN_EV: begin
				state_d = sts.scan_last ? ghull_pkg::ST_INIT : ghull_pkg::ST_MIN_RD;
			end
			ghull_pkg::ST_INIT:   state_d = ghull_pkg::ST_SEL_RD;
			ghull_pkg::ST_SEL_RD: state_d = ghull_pkg::ST_SEL_EV;
			ghull_pkg::ST_SEL_EV: begin
				if (!sts.skip) begin
					state_d = ghull_pkg::ST_CORD_GO;
				end else begin
					state_d = sts.scan_last ? ghull_pkg::ST_PICK : ghull_pkg::ST_SEL_RD;
				end
			end
			ghull_pkg::ST_CORD_GO: state_d = ghull_pkg::ST_CORD_WAIT;
			ghull_pkg::ST_CORD_WAIT: begin
				if (!sts.cord_busy) state_d = ghull_pkg::ST_CMP;
			end
			ghull_pkg::ST_CMP: begin
				state_d = sts.scan_last ? ghull_pkg::ST_PICK : ghull_pkg::ST_SEL_RD;
			end
			ghull_pkg::ST_PICK: begin
				priority if (!sts.found || sts.step_ovf) begin
					state_d = ghull_pkg::ST_ERR;
				end else if (sts.closes) begin
					state_d = ghull_pkg::ST_EMIT_RD;
				end else if (sts.k_full) begin
					state_d = ghull_pkg::ST_ERR;
				end else begin
					state_d = ghull_pkg::ST_SEL_RD;
				end
			end
			ghull_pkg::ST_EMIT_RD: state_d = ghull_pkg::ST_EMIT_EV;
			ghull_pkg::ST_EMIT_EV: begin
				if (sts.out_free) begin
					state_d = sts.emit_last ? ghull_pkg::ST_CLEAR : ghull_pkg::ST_EMIT_RD;
				end
			end
			ghull_pkg::ST_ERR: begin
				if (sts.out_free) state_d = ghull_pkg::ST_CLEAR;
			end
			ghull_pkg::ST_CLEAR: state_d = ghull_pkg::ST_IDLE;
			default: state_d = ghull_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.err  = ghull_pkg::ERR_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ghull_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_pt = in_valid;
			end
			ghull_pkg::ST_CHECK: begin
				cmd.scan_clr = 1'b1;
				cmd.set_err  = sts.count_lt2;
				cmd.err      = ghull_pkg::ERR_FEW_POINTS;
			end
			ghull_pkg::ST_MIN_EV: begin
				cmd.min_eval = 1'b1;
				cmd.scan_inc = !sts.scan_last;
			end
			ghull_pkg::ST_INIT: cmd.wrap_init = 1'b1;
			ghull_pkg::ST_SEL_EV: begin
				cmd.cand_load = !sts.skip;
				cmd.scan_inc  = sts.skip && !sts.scan_last;
			end
			ghull_pkg::ST_CORD_GO: cmd.cord_start = 1'b1;
			ghull_pkg::ST_CMP: begin
				cmd.cand_cmp = 1'b1;
				cmd.scan_inc = !sts.scan_last;
			end
			ghull_pkg::ST_PICK: begin
				priority if (!sts.found) begin
					cmd.set_err = 1'b1;
					cmd.err     = ghull_pkg::ERR_NO_CANDIDATE;
				end else if (sts.step_ovf) begin
					cmd.set_err = 1'b1;
					cmd.err     = ghull_pkg::ERR_STEP_OVERFLOW;
				end else if (sts.closes) begin
					cmd.pick     = 1'b1;
					cmd.scan_clr = 1'b1;
				end else if (sts.k_full) begin
					cmd.set_err = 1'b1;
					cmd.err     = ghull_pkg::ERR_STEP_OVERFLOW;
				end else begin
					cmd.pick    = 1'b1;
					cmd.advance = 1'b1;
				end
			end
			ghull_pkg::ST_EMIT_EV: begin
				cmd.emit_vertex = sts.out_free;
				cmd.scan_inc    = sts.out_free && !sts.emit_last;
			end
			ghull_pkg::ST_ERR:   cmd.emit_err   = sts.out_free;
			ghull_pkg::ST_CLEAR: cmd.wrap_clear = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== hdl/gift_wrapping_convex_hull.sv =====
// Points load one per cycle while idle; an item without last_point keeps input
// ready. The item with last_point starts a wrap of n points, input held off
// throughout: a lowest-point scan, then per hull step a scan of the points with
// a CORDIC angle per candidate (28 CORDIC iterations on one shared unit).
// Vertices leave from the vertex list as the output frees, then the set clears.
// arst_n clears the controller, fill count and used flags; store data is not reset.
// ----------------------------------------------------------------------------
// gift_wrapping_convex_hull
// Jarvis march convex hull over a loaded 2-D point set.
// ----------------------------------------------------------------------------
module gift_wrapping_convex_hull #(
	parameter int MAX_POINTS  = 64,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ghull_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ghull_pkg::out_item_t out_data
);
	ghull_pkg::cmd_t    cmd;
	ghull_pkg::status_t sts;

	ghull_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (in_data.last_point),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ghull_dp #(
		.MAX_POINTS  (MAX_POINTS),
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/ghull_chk.sv =====
// ----------------------------------------------------------------------------
// ghull_chk
// Port-level checks for the hull block, bound onto the top level.
// ----------------------------------------------------------------------------
module ghull_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input ghull_pkg::in_item_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input ghull_pkg::out_item_t out_data
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an error result is a closing result with zero coordinates
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.error_code != ghull_pkg::ERR_NONE) |->
		out_data.last_vertex && (out_data.hull_x == '0) && (out_data.hull_y == '0))
		else $error("malformed error result");

	// a transfer with last_point starts a wrap that holds off input
	a_wrap_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_point |=> !in_ready)
		else $error("input taken during wrap");

	// plain points load back to back
	a_load_rate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last_point |=> in_ready)
		else $error("load stalled");

endmodule

bind gift_wrapping_convex_hull ghull_chk u_ghull_chk (.*);

// ===== tb/tb_gift_wrapping_convex_hull.sv =====
// ----------------------------------------------------------------------------
// tb_gift_wrapping_convex_hull
// Loads 2-D point sets through the input channel and checks each emitted
// hull vertex or error result against a Jarvis march predictor with its own
// CORDIC angle model. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_gift_wrapping_convex_hull;

	localparam int     STORE_DEPTH = 64;
	localparam int     IDLE_LIMIT  = 400000;
	localparam longint FULL_TURN   = 64'sd65536;
	localparam longint HALF_TURN   = 64'sd32768;

	localparam logic [31:0] ATAN_TURNS [28] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	ghull_pkg::in_item_t  in_data;
	logic                 out_valid;
	logic                 out_ready;
	ghull_pkg::out_item_t out_data;

	ghull_pkg::in_item_t  pending_points[$];
	ghull_pkg::out_item_t hull_expected[$];
	longint    set_x[STORE_DEPTH];
	longint    set_y[STORE_DEPTH];
	bit        set_used[STORE_DEPTH];
	int        set_count;
	int        fail_count;
	int        in_idle;
	int        out_stall;
	int        quiet_cycles;

	gift_wrapping_convex_hull u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// first-quadrant angle of (ax, ay), full turn = 65536
	function automatic longint quarter_angle(longint ax, longint ay);
		longint x, y, z, nx;
		if (ay == 0)
			return 0;
		if (ax == 0)
			return 64'sd16384;
		x = ax <<< 16;
		y = ay <<< 16;
		z = 0;
		for (int i = 0; i < 28; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + longint'(ATAN_TURNS[i]);
			end else begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - longint'(ATAN_TURNS[i]);
			end
			x = nx;
		end
		if (z < 0)
			z = 0;
		if (z > (64'sd1 <<< 30))
			z = 64'sd1 <<< 30;
		return (z + 64'sd32768) >>> 16;
	endfunction

	function automatic longint heading(longint dx, longint dy);
		longint q;
		q = quarter_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
		if (dy >= 0)
			return dx >= 0 ? HALF_TURN + q : FULL_TURN - q;
		return dx < 0 ? q : HALF_TURN - q;
	endfunction

	function automatic ghull_pkg::out_item_t hull_result(longint x, longint y,
		ghull_pkg::err_code_t err);
		ghull_pkg::out_item_t r;
		r.hull_x      = ghull_pkg::coord_t'(x);
		r.hull_y      = ghull_pkg::coord_t'(y);
		r.last_vertex = 1'b0;
		r.error_code  = err;
		return r;
	endfunction

	task automatic push_error(ghull_pkg::err_code_t err);
		ghull_pkg::out_item_t r;
		r = hull_result(0, 0, err);
		r.last_vertex = 1'b1;
		hull_expected = {hull_expected, r};
	endtask

	// wrap the loaded set and queue the vertices or the error result it yields
	task automatic wrap_set();
		ghull_pkg::out_item_t verts[$];
		longint    sx, sy, cx, cy, prev, best_diff, best_angle, a;
		int        best, steps;
		bit        found;
		if (set_count < 2) begin
			push_error(ghull_pkg::ERR_FEW_POINTS);
			return;
		end
		sx = set_x[0];
		sy = set_y[0];
		for (int i = 1; i < set_count; i++)
			if (set_y[i] < sy) begin
				sx = set_x[i];
				sy = set_y[i];
			end
		cx = sx;
		cy = sy;
		prev = FULL_TURN;
		steps = 0;
		verts = {verts, hull_result(sx, sy, ghull_pkg::ERR_NONE)};
		forever begin
			best_diff = FULL_TURN;
			best_angle = 0;
			best = 0;
			found = 1'b0;
			for (int i = 0; i < set_count; i++) begin
				if (set_used[i] || (set_x[i] == cx && set_y[i] == cy))
					continue;
				a = heading(set_x[i] - cx, set_y[i] - cy);
				if (a <= prev && prev - a < best_diff) begin
					best_diff = prev - a;
					best_angle = a;
					best = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				push_error(ghull_pkg::ERR_NO_CANDIDATE);
				return;
			end
			steps++;
			if (steps > set_count) begin
				push_error(ghull_pkg::ERR_STEP_OVERFLOW);
				return;
			end
			set_used[best] = 1'b1;
			prev = best_angle;
			if (set_x[best] == sx && set_y[best] == sy)
				break;
			if (verts.size() >= STORE_DEPTH) begin
				push_error(ghull_pkg::ERR_STEP_OVERFLOW);
				return;
			end
			cx = set_x[best];
			cy = set_y[best];
			verts = {verts, hull_result(cx, cy, ghull_pkg::ERR_NONE)};
		end
		verts[verts.size()-1].last_vertex = 1'b1;
		foreach (verts[i])
			hull_expected = {hull_expected, verts[i]};
	endtask

	task automatic load_point(ghull_pkg::in_item_t it);
		if (set_count < STORE_DEPTH) begin
			set_x[set_count] = longint'(it.point_x);
			set_y[set_count] = longint'(it.point_y);
			set_count++;
		end
		if (it.last_point) begin
			wrap_set();
			set_count = 0;
			foreach (set_used[i])
				set_used[i] = 1'b0;
		end
	endtask

	task automatic queue_point(int x, int y, bit last);
		ghull_pkg::in_item_t it;
		it.point_x    = ghull_pkg::coord_t'(x);
		it.point_y    = ghull_pkg::coord_t'(y);
		it.last_point = last;
		pending_points = {pending_points, it};
	endtask

	// shapes: 0 full range, 1 tight cluster, 2 all equal, 3 grid of random steps
	task automatic queue_set(int n, int shape);
		int cx, cy, step_x, step_y;
		cx = $urandom_range(0, 65000) - 32500;
		cy = $urandom_range(0, 65000) - 32500;
		step_x = $urandom_range(0, 40) - 20;
		step_y = $urandom_range(0, 40) - 20;
		for (int i = 0; i < n; i++) begin
			case (shape)
				0: queue_point($urandom_range(0, 65535) - 32768,
					$urandom_range(0, 65535) - 32768, i == n - 1);
				1: queue_point(cx + $urandom_range(0, 8) - 4,
					cy + $urandom_range(0, 8) - 4, i == n - 1);
				2: queue_point(cx, cy, i == n - 1);
				default: queue_point(cx + step_x * ($urandom_range(0, 10) - 5),
					cy + step_y * ($urandom_range(0, 10) - 5), i == n - 1);
			endcase
		end
	endtask

	// hold valid and payload until the transfer, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		bit                  fire;
		bit                  next_valid;
		ghull_pkg::in_item_t next_item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			in_idle  = 0;
		end else begin
			fire = in_valid && in_ready;
			next_valid = in_valid && !fire;
			next_item = in_data;
			if (fire)
				load_point(in_data);
			if (!next_valid) begin
				if (in_idle > 0)
					in_idle--;
				else if (pending_points.size() > 0) begin
					if (pending_points.size() > 40 && $urandom_range(0, 5) == 0)
						in_idle = $urandom_range(1, 14);
					else begin
						next_valid = 1'b1;
						next_item = pending_points.pop_front();
					end
				end
			end
			in_valid <= next_valid;
			in_data  <= next_item;
		end
	end

	// check each result transfer and keep the watchdog
	always @(posedge clk or negedge arst_n) begin
		ghull_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
			quiet_cycles = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (hull_expected.size() == 0) begin
					$error("unexpected hull result %p", out_data);
					fail_count++;
				end else begin
					want = hull_expected.pop_front();
					if (out_data.hull_x !== want.hull_x) begin
						$error("hull_x expected %0d actual %0d", want.hull_x, out_data.hull_x);
						fail_count++;
					end
					if (out_data.hull_y !== want.hull_y) begin
						$error("hull_y expected %0d actual %0d", want.hull_y, out_data.hull_y);
						fail_count++;
					end
					if (out_data.last_vertex !== want.last_vertex) begin
						$error("last_vertex expected %0b actual %0b",
							want.last_vertex, out_data.last_vertex);
						fail_count++;
					end
					if (out_data.error_code !== want.error_code) begin
						$error("error_code expected %s actual %0d",
							want.error_code.name(), out_data.error_code);
						fail_count++;
					end
				end
			end
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("gift_wrapping_convex_hull verification failed");
				$finish;
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else if (pending_points.size() > 40 && $urandom_range(0, 5) == 0) begin
				out_stall = $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		int items;
		int n;
		fail_count = 0;
		set_count = 0;
		arst_n = 1'b0;
		// lone point: too few
		queue_point(5, -7, 1'b1);
		// two identical points: no candidate
		queue_point(100, 100, 1'b0);
		queue_point(100, 100, 1'b1);
		// coordinate extremes
		queue_point(-32768, -32768, 1'b0);
		queue_point(32767, -32768, 1'b0);
		queue_point(32767, 32767, 1'b0);
		queue_point(-32768, 32767, 1'b0);
		queue_point(0, 0, 1'b1);
		// collinear, a tie on lowest y and a repeat of the start
		queue_point(0, 0, 1'b0);
		queue_point(10, 10, 1'b0);
		queue_point(20, 20, 1'b1);
		queue_point(3, -1, 1'b0);
		queue_point(-3, -1, 1'b0);
		queue_point(3, -1, 1'b0);
		queue_point(0, 6, 1'b0);
		queue_point(1, 1, 1'b1);
		// axis-aligned neighbors
		queue_point(0, 0, 1'b0);
		queue_point(0, 9, 1'b0);
		queue_point(-9, 0, 1'b0);
		queue_point(9, 0, 1'b1);
		// store overflow: the two extra points are dropped, the last flag still wraps
		queue_set(STORE_DEPTH + 2, 1);
		items = pending_points.size();
		while (items < 320) begin
			case ($urandom_range(0, 19))
				0: n = 1;
				1: n = $urandom_range(20, 40);
				default: n = $urandom_range(2, 10);
			endcase
			queue_set(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
			items += n;
		end
		out_ready = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_points.size() > 0 || in_valid || hull_expected.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("gift_wrapping_convex_hull verification clean");
		else
			$display("gift_wrapping_convex_hull verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ghull_pkg.sv
hdl/ghull_cordic.sv
hdl/ghull_dp.sv
hdl/ghull_ctrl.sv
hdl/gift_wrapping_convex_hull.sv
hdl/ghull_chk.sv
tb/tb_gift_wrapping_convex_hull.sv
